// File: rtl/cghm_pkg.sv
// Shared constants and types for the codepoint glyph hash map.
`default_nettype none

package cghm_pkg;

   localparam int CAPACITY  = 4096;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CP_W      = 21;
   localparam int GLYPH_W   = 16;
   localparam int SIZE_W    = 13;
   localparam int COUNT_W   = 13;
   localparam int BITCNT_W  = $clog2(CP_W);
   localparam int MIN_SIZE  = 3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_MISSING  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_CACHED   = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      GLYPH_NONE   = 2'd0,
      GLYPH_NEW    = 2'd1,
      GLYPH_STORED = 2'd2
   } glyph_sel_type;

   typedef struct packed {
      logic               valid;
      logic [CP_W-1:0]    key;
      logic [GLYPH_W-1:0] glyph;
   } entry_type;

   typedef struct packed {
      logic          clear_step;
      logic          load_item;
      logic          div_step;
      logic          mem_read;
      logic          probe_next;
      logic          mem_write;
      logic          set_result;
      status_type    result_code;
      glyph_sel_type glyph_sel;
      logic          load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic size_small;
      logic div_last;
      logic slot_valid;
      logic key_match;
      logic idx_zero;
      logic probe_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/cghm_ctrl.sv
// Controller state machine that sequences clearing, division, probing and response.
`default_nettype none

module cghm_ctrl import cghm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_DIVIDE  = 6'b000100,
      S_READ    = 6'b001000,
      S_CHECK   = 6'b010000,
      S_RESPOND = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.result_code = ST_MISSING;
      cmd.glyph_sel = GLYPH_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (stat.size_small) begin
                  cmd.set_result = 1'b1;
                  cmd.result_code = ST_INSERTED;
                  cmd.glyph_sel = GLYPH_NONE;
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!stat.slot_valid) begin
               cmd.set_result = 1'b1;
               if (stat.idx_zero) begin
                  cmd.result_code = ST_MISSING;
                  cmd.glyph_sel = GLYPH_NONE;
               end else begin
                  cmd.mem_write = 1'b1;
                  cmd.result_code = ST_INSERTED;
                  cmd.glyph_sel = GLYPH_NEW;
               end
               state_in = S_RESPOND;
            end else if (stat.key_match) begin
               cmd.set_result = 1'b1;
               cmd.result_code = ST_CACHED;
               cmd.glyph_sel = GLYPH_STORED;
               state_in = S_RESPOND;
            end else if (stat.probe_last) begin
               cmd.set_result = 1'b1;
               cmd.result_code = ST_FULL;
               cmd.glyph_sel = GLYPH_NONE;
               state_in = S_RESPOND;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = S_READ;
            end
         end
         S_RESPOND: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cghm_dpath.sv
// Datapath with the slot memory, the two serial dividers, the probe logic and the output register.
`default_nettype none

module cghm_dpath import cghm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic                csr_write_enable,
   input  wire logic [SIZE_W-1:0]   csr_write_data,
   input  wire logic [CP_W-1:0]     req_codepoint,
   input  wire logic [GLYPH_W-1:0]  req_index_if_new,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [GLYPH_W-1:0]       rsp_glyph_index,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   entry_type mem [CAPACITY];

   logic [SIZE_W-1:0]   table_size_ff;
   logic [ADDR_W:0]     size_ff;
   logic [ADDR_W:0]     size_clamp;
   logic [CP_W-1:0]     cp_ff;
   logic [GLYPH_W-1:0]  idx_ff;
   logic [BITCNT_W-1:0] bit_cnt_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [ADDR_W-1:0]   step_rem_ff;
   logic [ADDR_W:0]     probe_cnt_ff;
   logic [ADDR_W-1:0]   clear_addr_ff;
   logic [COUNT_W-1:0]  filled_count_ff;
   entry_type           rd_entry_ff;
   status_type          result_code_ff;
   logic [GLYPH_W-1:0]  result_glyph_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [GLYPH_W-1:0]  rsp_glyph_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [ADDR_W:0]     div2;
   logic [ADDR_W:0]     trial1;
   logic [ADDR_W:0]     trial2;
   logic [ADDR_W-1:0]   rem1_in;
   logic [ADDR_W-1:0]   rem2_in;
   logic [ADDR_W-1:0]   step;
   logic [ADDR_W:0]     pos_sum;
   logic [ADDR_W-1:0]   pos_adv;
   logic [GLYPH_W-1:0]  glyph_in;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_entry;
   logic                wr_en;

   assign size_clamp = (table_size_ff > SIZE_W'(CAPACITY)) ? (ADDR_W+1)'(CAPACITY)
                                                            : table_size_ff[ADDR_W:0];

   assign div2    = size_ff - (ADDR_W+1)'(2);
   assign trial1  = {pos_ff, cp_ff[bit_cnt_ff]};
   assign trial2  = {step_rem_ff, cp_ff[bit_cnt_ff]};
   assign rem1_in = (trial1 >= size_ff) ? ADDR_W'(trial1 - size_ff) : trial1[ADDR_W-1:0];
   assign rem2_in = (trial2 >= div2) ? ADDR_W'(trial2 - div2) : trial2[ADDR_W-1:0];

   assign step    = (step_rem_ff == '0) ? ADDR_W'(1) : step_rem_ff;
   assign pos_sum = {1'b0, pos_ff} + {1'b0, step};
   assign pos_adv = (pos_sum >= size_ff) ? ADDR_W'(pos_sum - size_ff) : pos_sum[ADDR_W-1:0];

   always_comb begin
      case (cmd.glyph_sel)
         GLYPH_NEW:    glyph_in = idx_ff;
         GLYPH_STORED: glyph_in = rd_entry_ff.glyph;
         default:      glyph_in = '0;
      endcase
   end

   assign wr_en    = cmd.clear_step | cmd.mem_write;
   assign wr_addr  = cmd.clear_step ? clear_addr_ff : pos_ff;
   assign wr_entry = cmd.clear_step ? entry_type'('0) : entry_type'({1'b1, cp_ff, idx_ff});

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.mem_read) begin
         rd_entry_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= '0;
         clear_addr_ff   <= '0;
         filled_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            table_size_ff <= csr_write_data;
         end
         if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         end
         if (cmd.mem_write && (filled_count_ff < COUNT_MAX)) begin
            filled_count_ff <= filled_count_ff + COUNT_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cp_ff        <= req_codepoint;
         idx_ff       <= req_index_if_new;
         size_ff      <= size_clamp;
         bit_cnt_ff   <= BITCNT_W'(CP_W - 1);
         pos_ff       <= '0;
         step_rem_ff  <= '0;
         probe_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         pos_ff      <= rem1_in;
         step_rem_ff <= rem2_in;
         bit_cnt_ff  <= bit_cnt_ff - BITCNT_W'(1);
      end
      if (cmd.probe_next) begin
         pos_ff       <= pos_adv;
         probe_cnt_ff <= probe_cnt_ff + (ADDR_W+1)'(1);
      end
      if (cmd.set_result) begin
         result_code_ff  <= cmd.result_code;
         result_glyph_ff <= glyph_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= result_code_ff;
         rsp_glyph_ff  <= result_glyph_ff;
         rsp_count_ff  <= filled_count_ff;
      end
   end

   assign stat.clear_last = (clear_addr_ff == {ADDR_W{1'b1}});
   assign stat.size_small = (table_size_ff < SIZE_W'(MIN_SIZE));
   assign stat.div_last   = (bit_cnt_ff == '0);
   assign stat.slot_valid = rd_entry_ff.valid;
   assign stat.key_match  = (rd_entry_ff.key == cp_ff);
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.probe_last = ((probe_cnt_ff + (ADDR_W+1)'(1)) == size_ff);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_glyph_index = rsp_glyph_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_read |-> ({1'b0, pos_ff} < size_ff))
      else $error("probe position outside the table");

   a_write_empty_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> (!rd_entry_ff.valid && (idx_ff != '0)))
      else $error("insert into a filled slot or with an absent glyph");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (filled_count_ff >= $past(filled_count_ff)))
      else $error("entry count decreased");
`endif

endmodule

`default_nettype wire

// File: rtl/codepoint_glyph_hash_map.sv
// Top level of the codepoint glyph hash map.
// After reset the block sweeps its 4096-slot memory, one slot per cycle,
// and stalls requests until the sweep ends and while a request is in progress. A request with
// a table size of 3 or more goes through the two serial remainders of the 21-bit codepoint,
// then P probes (1 to the table size clamped to 4096), each a registered read of the slot
// memory followed by a check, then the load of the output register, which waits while the
// output is stalled. A table size below 3 skips the remainders and probes. Each word is
// accepted on valid high with stall low; the result waits in an output register.
`default_nettype none

module codepoint_glyph_hash_map import cghm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [SIZE_W-1:0]   csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CP_W-1:0]     req_codepoint,
   input  wire logic [GLYPH_W-1:0]  req_index_if_new,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [GLYPH_W-1:0]       rsp_glyph_index,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   cghm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cghm_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_codepoint    (req_codepoint),
      .req_index_if_new (req_index_if_new),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_glyph_index  (rsp_glyph_index),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule

`default_nettype wire
